@@ src/pdpe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pdpe_pkg;

  localparam int unsigned POS_W  = 10;
  localparam int unsigned MOVE_W = 12;
  localparam int unsigned SRC_W  = 12;
  localparam int unsigned PROD_W = SRC_W + POS_W;

  // Operations
  localparam logic [1:0] OP_BUTTON = 2'd0;
  localparam logic [1:0] OP_SOURCE = 2'd1;
  localparam logic [1:0] OP_POLL   = 2'd2;
  localparam logic [1:0] OP_HOST   = 2'd3;

  // Link kinds
  localparam logic [1:0] LINK_SLAVE = 2'd0;
  localparam logic [1:0] LINK_IKAT  = 2'd1;

  // Device kinds
  localparam logic [1:0] DEV_JOYSTICK = 2'd1;
  localparam logic [1:0] DEV_TABLET   = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_LINK_KIND  = 3'd0;
  localparam logic [2:0] REG_DEV_KIND   = 3'd1;
  localparam logic [2:0] REG_STEP_SIZE  = 3'd2;
  localparam logic [2:0] REG_SLAVE_EN   = 3'd3;
  localparam logic [2:0] REG_IKAT_UP    = 3'd4;

  // Button ids
  localparam logic [2:0] BTN_LEFT  = 3'd0;
  localparam logic [2:0] BTN_RIGHT = 3'd1;
  localparam logic [2:0] BTN_UP    = 3'd2;
  localparam logic [2:0] BTN_DOWN  = 3'd3;
  localparam logic [2:0] BTN_ONE   = 3'd4;
  localparam logic [2:0] BTN_TWO   = 3'd5;

  // Identification bytes
  localparam logic [7:0] ID_MOUSE    = 8'hCD;
  localparam logic [7:0] ID_JOYSTICK = 8'hCA;
  localparam logic [7:0] ID_TABLET   = 8'hD4;

  localparam logic [POS_W-1:0] IKAT_ABS_MAX = 10'h3FF;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [2:0]       button_id;
    logic             button_level;
    logic [SRC_W-1:0] source_x;
    logic [SRC_W-1:0] source_y;
    logic [SRC_W-1:0] source_width;
    logic [SRC_W-1:0] source_height;
    logic [POS_W-1:0] host_x;
    logic [POS_W-1:0] host_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] report_byte;
    logic       report_link;
    logic       report_last;
  } out_item_t;

endpackage
`default_nettype wire

@@ src/pointer_device_packet_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pointing device report encoder.
// Input channel (in_valid/in_ready/in_data) takes one operation per item:
// button event, source coordinate, poll or host position set. A poll may
// return one identification byte or four report bytes on the output
// channel (out_valid/out_ready/out_data); other operations return none.
// Configuration writes (cfg_valid/cfg_ready/cfg_index/cfg_data) are
// always accepted and should be issued while the block is idle.
// Button, host-set and unchanged source items are done in the idle state.
// A changed source coordinate is scaled by a multiply and a divide, the
// two axes going one after the other through a single multiplier and a
// shared restoring divider giving one quotient bit per cycle. A poll
// sends its bytes as the receiver takes them; an IKAT tablet report
// first does two scaling divisions.
// in_ready is low while an item is being worked on or its bytes are
// being sent; a stalled receiver holds the current byte and the block.
// Synchronous active-low reset returns the control registers to their defaults,
// position and moves to zero and buttons released.
module pointer_device_packet_encoder #(
  parameter int unsigned SCREEN_X_MAX = 768,
  parameter int unsigned SCREEN_Y_MAX = 560
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire pdpe_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire                       out_ready,
  output pdpe_pkg::out_item_t       out_data,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire [2:0]                 cfg_index,
  input  wire [7:0]                 cfg_data
);

  localparam int unsigned PW = pdpe_pkg::POS_W;
  localparam int unsigned MW = pdpe_pkg::MOVE_W;
  localparam int unsigned SW = pdpe_pkg::SRC_W;
  localparam int unsigned DW = pdpe_pkg::PROD_W;
  localparam logic [PW-1:0] XMAX = PW'(SCREEN_X_MAX);
  localparam logic [PW-1:0] YMAX = PW'(SCREEN_Y_MAX);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_SEND = 2'd3;

  localparam logic [1:0] PH_SRC_X = 2'd0;
  localparam logic [1:0] PH_SRC_Y = 2'd1;
  localparam logic [1:0] PH_IK_X  = 2'd2;
  localparam logic [1:0] PH_IK_Y  = 2'd3;

  localparam logic [4:0] DIV_LAST = 5'(DW - 1);

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [SW-1:0] dvs_r, dvs_nxt;
  logic [PW-1:0] first_r, first_nxt;

  logic [1:0] link_r, link_nxt;
  logic [1:0] dev_r, dev_nxt;
  logic [7:0] step_r, step_nxt;
  logic       sen_r, sen_nxt;
  logic       ikup_r, ikup_nxt;

  logic [PW-1:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic [MW-1:0] mx_r, mx_nxt, my_r, my_nxt;
  logic [5:0]    btn_r, btn_nxt;
  logic          mov_r, mov_nxt, stat_r, stat_nxt, chg_r, chg_nxt, ident_r, ident_nxt;
  logic [SW-1:0] ls_x_r, ls_x_nxt, ls_y_r, ls_y_nxt, ls_w_r, ls_w_nxt, ls_h_r, ls_h_nxt;

  logic [7:0] buf_r [4];
  logic [7:0] buf_nxt [4];
  logic [1:0] idx_r, idx_nxt;
  logic       olink_r, olink_nxt;

  logic          tablet, any_flag;
  logic [SW-1:0] mul_a;
  logic [PW-1:0] mul_b, qmax;
  logic [SW:0]   trial_sh, trial_sub;
  logic [PW-1:0] q_clamped;
  logic [5:0]    b_tmp;
  logic [MW-1:0] sy_mv;
  logic [MW:0]   sum_x, sum_y;
  logic [7:0]    cx, cy;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_SEND);
  assign out_data.report_byte = buf_r[idx_r];
  assign out_data.report_link = olink_r;
  assign out_data.report_last = (idx_r == 2'd3);

  assign tablet   = (dev_r == pdpe_pkg::DEV_TABLET);
  assign any_flag = mov_r | stat_r | chg_r;

  // Clamp a signed move to one byte
  function automatic logic [7:0] clamp8(input logic [MW-1:0] v);
    logic signed [MW-1:0] s;
    s = $signed(v);
    if (s < -$signed(MW'(128)))     clamp8 = 8'h80;
    else if (s > $signed(MW'(127))) clamp8 = 8'h7F;
    else                            clamp8 = v[7:0];
  endfunction

  // Clamp a stepped position to 0..max
  function automatic logic [PW-1:0] clamp_pos(input logic [MW:0] v, input logic [PW-1:0] mx);
    if (v[MW])                         clamp_pos = '0;
    else if (v > {{(MW+1-PW){1'b0}}, mx}) clamp_pos = mx;
    else                               clamp_pos = v[PW-1:0];
  endfunction

  // Select multiplier operands and quotient limit by phase
  always_comb begin
    case (phase_r)
      PH_SRC_X: begin mul_a = ls_x_r; mul_b = XMAX; qmax = XMAX; end
      PH_SRC_Y: begin mul_a = ls_y_r; mul_b = YMAX; qmax = YMAX; end
      PH_IK_X:  begin
        mul_a = {{(SW-PW){1'b0}}, ax_r}; mul_b = pdpe_pkg::IKAT_ABS_MAX;
        qmax = pdpe_pkg::IKAT_ABS_MAX;
      end
      default:  begin
        mul_a = {{(SW-PW){1'b0}}, ay_r}; mul_b = pdpe_pkg::IKAT_ABS_MAX;
        qmax = pdpe_pkg::IKAT_ABS_MAX;
      end
    endcase
  end

  // One restoring divider step
  assign trial_sh  = {rem_r, quo_r[DW-1]};
  assign trial_sub = trial_sh - {1'b0, dvs_r};

  always_comb begin
    logic [DW-1:0] qfin;
    qfin = {quo_r[DW-2:0], ~trial_sub[SW]};
    if (qfin > {{(DW-PW){1'b0}}, qmax}) q_clamped = qmax;
    else                                q_clamped = qfin[PW-1:0];
  end

  assign sy_mv = {2'b00, q_clamped} - {2'b00, ay_r};

  // Sequencer and state update
  always_comb begin
    state_nxt = state_r; phase_nxt = phase_r; cnt_nxt = cnt_r;
    rem_nxt = rem_r; quo_nxt = quo_r; dvs_nxt = dvs_r; first_nxt = first_r;
    link_nxt = link_r; dev_nxt = dev_r; step_nxt = step_r;
    sen_nxt = sen_r; ikup_nxt = ikup_r;
    ax_nxt = ax_r; ay_nxt = ay_r; mx_nxt = mx_r; my_nxt = my_r; btn_nxt = btn_r;
    mov_nxt = mov_r; stat_nxt = stat_r; chg_nxt = chg_r; ident_nxt = ident_r;
    ls_x_nxt = ls_x_r; ls_y_nxt = ls_y_r; ls_w_nxt = ls_w_r; ls_h_nxt = ls_h_r;
    buf_nxt = buf_r; idx_nxt = idx_r; olink_nxt = olink_r;
    b_tmp = btn_r; sum_x = '0; sum_y = '0;
    cx = clamp8(mx_r); cy = clamp8(my_r);

    // Take configuration writes
    if (cfg_valid) begin
      case (cfg_index)
        pdpe_pkg::REG_LINK_KIND: link_nxt = cfg_data[1:0];
        pdpe_pkg::REG_DEV_KIND:  dev_nxt  = cfg_data[1:0];
        pdpe_pkg::REG_STEP_SIZE: step_nxt = cfg_data;
        pdpe_pkg::REG_SLAVE_EN:  sen_nxt  = cfg_data[0];
        pdpe_pkg::REG_IKAT_UP:   ikup_nxt = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.opcode)
            pdpe_pkg::OP_BUTTON: begin
              if (in_data.button_id <= pdpe_pkg::BTN_TWO) begin
                if (in_data.button_id < pdpe_pkg::BTN_ONE)
                  b_tmp[in_data.button_id] = in_data.button_level;
                if (b_tmp[3:0] != 4'd0) begin
                  mov_nxt = 1'b1;
                  if (b_tmp[pdpe_pkg::BTN_LEFT] && !b_tmp[pdpe_pkg::BTN_RIGHT])
                    mx_nxt = -{4'd0, step_r};
                  else if (b_tmp[pdpe_pkg::BTN_RIGHT] && !b_tmp[pdpe_pkg::BTN_LEFT])
                    mx_nxt = {4'd0, step_r};
                  else mx_nxt = '0;
                  if (b_tmp[pdpe_pkg::BTN_UP] && !b_tmp[pdpe_pkg::BTN_DOWN])
                    my_nxt = -{4'd0, step_r};
                  else if (b_tmp[pdpe_pkg::BTN_DOWN] && !b_tmp[pdpe_pkg::BTN_UP])
                    my_nxt = {4'd0, step_r};
                  else my_nxt = '0;
                  sum_x = {3'b000, ax_r} + {mx_nxt[MW-1], mx_nxt};
                  sum_y = {3'b000, ay_r} + {my_nxt[MW-1], my_nxt};
                  ax_nxt = clamp_pos(sum_x, XMAX);
                  ay_nxt = clamp_pos(sum_y, YMAX);
                end else begin
                  mov_nxt = 1'b0;
                  if (mx_r != '0 || my_r != '0) begin
                    mx_nxt = '0; my_nxt = '0;
                    if (!tablet) stat_nxt = 1'b1;
                  end
                end
                if (in_data.button_id >= pdpe_pkg::BTN_ONE &&
                    b_tmp[in_data.button_id] != in_data.button_level) begin
                  chg_nxt = 1'b1;
                  b_tmp[in_data.button_id] = in_data.button_level;
                end
                btn_nxt = b_tmp;
              end
            end
            pdpe_pkg::OP_SOURCE: begin
              if (in_data.source_x != ls_x_r || in_data.source_y != ls_y_r ||
                  in_data.source_width != ls_w_r || in_data.source_height != ls_h_r) begin
                ls_x_nxt = in_data.source_x; ls_y_nxt = in_data.source_y;
                ls_w_nxt = in_data.source_width; ls_h_nxt = in_data.source_height;
                phase_nxt = PH_SRC_X;
                state_nxt = S_MUL;
              end else begin
                mx_nxt = '0; my_nxt = '0;
                if (!tablet && mov_r) stat_nxt = 1'b1;
                mov_nxt = 1'b0;
              end
            end
            pdpe_pkg::OP_POLL: begin
              if (link_r == pdpe_pkg::LINK_SLAVE) begin
                olink_nxt = 1'b0;
                if (sen_r && !ident_r) begin
                  ident_nxt = 1'b1;
                  buf_nxt[3] = tablet ? pdpe_pkg::ID_TABLET :
                               (dev_r == pdpe_pkg::DEV_JOYSTICK) ? pdpe_pkg::ID_JOYSTICK :
                               pdpe_pkg::ID_MOUSE;
                  idx_nxt = 2'd3;
                  state_nxt = S_SEND;
                end else begin
                  if (sen_r && any_flag) begin
                    buf_nxt[0] = {~tablet, 1'b0, btn_r[5], btn_r[4], 1'b1, ax_r[9:7]};
                    buf_nxt[1] = {1'b0, ax_r[6:0]};
                    buf_nxt[2] = {5'd0, ay_r[9:7]};
                    buf_nxt[3] = {1'b0, ay_r[6:0]};
                    idx_nxt = 2'd0;
                    state_nxt = S_SEND;
                  end
                  stat_nxt = 1'b0; chg_nxt = 1'b0;
                end
              end else if (link_r == pdpe_pkg::LINK_IKAT && ikup_r && any_flag) begin
                olink_nxt = 1'b1;
                idx_nxt = 2'd0;
                if (tablet) begin
                  phase_nxt = PH_IK_X;
                  state_nxt = S_MUL;
                end else begin
                  buf_nxt[0] = {2'b01, btn_r[5], btn_r[4], cy[7:6], cx[7:6]};
                  buf_nxt[1] = {2'b00, cx[5:0]};
                  buf_nxt[2] = {2'b00, cy[5:0]};
                  buf_nxt[3] = 8'h00;
                  state_nxt = S_SEND;
                end
              end else begin
                stat_nxt = 1'b0; chg_nxt = 1'b0;
              end
            end
            default: begin
              ax_nxt = in_data.host_x;
              ay_nxt = in_data.host_y;
            end
          endcase
        end
      end
      S_MUL: begin
        // Load the product and divisor
        quo_nxt = mul_a * mul_b;
        rem_nxt = '0;
        cnt_nxt = '0;
        case (phase_r)
          PH_SRC_X: dvs_nxt = ls_w_r;
          PH_SRC_Y: dvs_nxt = ls_h_r;
          PH_IK_X:  dvs_nxt = {{(SW-PW){1'b0}}, XMAX};
          default:  dvs_nxt = {{(SW-PW){1'b0}}, YMAX};
        endcase
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = trial_sub[SW] ? trial_sh[SW-1:0] : trial_sub[SW-1:0];
        quo_nxt = {quo_r[DW-2:0], ~trial_sub[SW]};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          case (phase_r)
            PH_SRC_X: begin
              first_nxt = q_clamped;
              phase_nxt = PH_SRC_Y;
              state_nxt = S_MUL;
            end
            PH_SRC_Y: begin
              mx_nxt = {2'b00, first_r} - {2'b00, ax_r};
              my_nxt = sy_mv;
              ax_nxt = first_r;
              ay_nxt = q_clamped;
              mov_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
            PH_IK_X: begin
              first_nxt = q_clamped;
              phase_nxt = PH_IK_Y;
              state_nxt = S_MUL;
            end
            default: begin
              buf_nxt[0] = {2'b01, btn_r[5], btn_r[4], first_r[9:6]};
              buf_nxt[1] = {2'b00, mov_r, 1'b0, q_clamped[9:6]};
              buf_nxt[2] = {2'b00, first_r[5:0]};
              buf_nxt[3] = {2'b10, q_clamped[5:0]};
              state_nxt = S_SEND;
            end
          endcase
        end
      end
      default: begin
        // Advance through the bytes as the receiver takes them
        if (out_ready) begin
          if (idx_r == 2'd3) state_nxt = S_IDLE;
          else               idx_nxt = idx_r + 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; phase_r <= PH_SRC_X; cnt_r <= '0;
      link_r <= '0; dev_r <= '0; step_r <= 8'd1; sen_r <= 1'b1; ikup_r <= 1'b1;
      ax_r <= '0; ay_r <= '0; mx_r <= '0; my_r <= '0; btn_r <= '0;
      mov_r <= 1'b0; stat_r <= 1'b0; chg_r <= 1'b0; ident_r <= 1'b0;
      ls_x_r <= '0; ls_y_r <= '0; ls_w_r <= '0; ls_h_r <= '0;
      idx_r <= '0; olink_r <= 1'b0;
    end else begin
      state_r <= state_nxt; phase_r <= phase_nxt; cnt_r <= cnt_nxt;
      link_r <= link_nxt; dev_r <= dev_nxt; step_r <= step_nxt;
      sen_r <= sen_nxt; ikup_r <= ikup_nxt;
      ax_r <= ax_nxt; ay_r <= ay_nxt; mx_r <= mx_nxt; my_r <= my_nxt; btn_r <= btn_nxt;
      mov_r <= mov_nxt; stat_r <= stat_nxt; chg_r <= chg_nxt; ident_r <= ident_nxt;
      ls_x_r <= ls_x_nxt; ls_y_r <= ls_y_nxt; ls_w_r <= ls_w_nxt; ls_h_r <= ls_h_nxt;
      idx_r <= idx_nxt; olink_r <= olink_nxt;
    end
  end

  // Datapath registers need no reset
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt; quo_r <= quo_nxt; dvs_r <= dvs_nxt; first_r <= first_nxt;
    buf_r <= buf_nxt;
  end

endmodule
`default_nettype wire

@@ verif/pdpe_checker.sv @@
`timescale 1ns / 1ps
module pdpe_checker #(
  parameter int SCREEN_X_MAX = 768,
  parameter int SCREEN_Y_MAX = 560
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_ready,
  input  pdpe_pkg::in_item_t   in_data,
  input  wire                  out_valid,
  input  wire                  out_ready,
  input  pdpe_pkg::out_item_t  out_data,
  input  wire                  cfg_valid,
  input  wire                  cfg_ready,
  input  wire [2:0]            cfg_index,
  input  wire [7:0]            cfg_data,
  output int                   fail_count,
  output int                   pending
);

  // configuration copy
  logic [1:0] link_kind;
  logic [1:0] device_kind;
  logic [7:0] step_size;
  logic       slave_en;
  logic       ikat_up;

  // pointer state
  int         pos_x, pos_y, mov_x, mov_y;
  logic [5:0] buttons;
  logic       moving, stationary, changed, identified;
  logic [pdpe_pkg::SRC_W-1:0] last_src [4];

  pdpe_pkg::out_item_t report_q[$];

  assign pending = report_q.size();

  function automatic int clamp_int(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int scale_axis(int p, int size, int maxv);
    int q;
    if (size == 0) return maxv;
    q = (p * maxv) / size;
    return (q > maxv) ? maxv : q;
  endfunction

  function automatic int axis_step(logic neg, logic pos, logic [7:0] stp);
    if (neg && !pos) return -int'(stp);
    if (pos && !neg) return int'(stp);
    return 0;
  endfunction

  function automatic logic [1:0] eff_kind();
    return (device_kind == 2'd3) ? 2'd0 : device_kind;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic queue_byte(logic [7:0] b, logic link, logic last);
    pdpe_pkg::out_item_t r;
    r.report_byte = b;
    r.report_link = link;
    r.report_last = last;
    report_q.push_back(r);
  endtask

  // apply a button event
  task automatic do_button(logic [2:0] id, logic lvl);
    logic tablet;
    tablet = (eff_kind() == pdpe_pkg::DEV_TABLET);
    if (id > pdpe_pkg::BTN_TWO) return;
    if (id < pdpe_pkg::BTN_ONE) buttons[id] = lvl;
    if (buttons[3:0] != 4'd0) begin
      moving = 1'b1;
      mov_x = axis_step(buttons[pdpe_pkg::BTN_LEFT], buttons[pdpe_pkg::BTN_RIGHT], step_size);
      mov_y = axis_step(buttons[pdpe_pkg::BTN_UP], buttons[pdpe_pkg::BTN_DOWN], step_size);
      pos_x = clamp_int(pos_x + mov_x, 0, SCREEN_X_MAX);
      pos_y = clamp_int(pos_y + mov_y, 0, SCREEN_Y_MAX);
    end else begin
      moving = 1'b0;
      if (mov_x != 0) begin
        mov_x = 0;
        if (!tablet) stationary = 1'b1;
      end
      if (mov_y != 0) begin
        mov_y = 0;
        if (!tablet) stationary = 1'b1;
      end
    end
    if (id >= pdpe_pkg::BTN_ONE && buttons[id] != lvl) begin
      changed = 1'b1;
      buttons[id] = lvl;
    end
  endtask

  // apply a source coordinate
  task automatic do_source(pdpe_pkg::in_item_t it);
    int tx, ty;
    if (it.source_x != last_src[0] || it.source_y != last_src[1] ||
        it.source_width != last_src[2] || it.source_height != last_src[3]) begin
      last_src[0] = it.source_x;
      last_src[1] = it.source_y;
      last_src[2] = it.source_width;
      last_src[3] = it.source_height;
      tx = scale_axis(it.source_x, it.source_width, SCREEN_X_MAX);
      ty = scale_axis(it.source_y, it.source_height, SCREEN_Y_MAX);
      mov_x = tx - pos_x;
      mov_y = ty - pos_y;
      pos_x = tx;
      pos_y = ty;
      moving = 1'b1;
    end else begin
      mov_x = 0;
      mov_y = 0;
      if (eff_kind() != pdpe_pkg::DEV_TABLET && moving) stationary = 1'b1;
      moving = 1'b0;
    end
  endtask

  // work out the report bytes of a poll
  task automatic do_poll();
    logic [1:0] kind;
    logic [7:0] btn, b0, b1, b2, b3;
    logic       any;
    int         x, y;
    kind = eff_kind();
    btn = (buttons[pdpe_pkg::BTN_TWO] ? 8'h20 : 8'h00) |
          (buttons[pdpe_pkg::BTN_ONE] ? 8'h10 : 8'h00);
    any = moving | stationary | changed;
    if (link_kind == pdpe_pkg::LINK_SLAVE) begin
      if (slave_en) begin
        if (!identified) begin
          identified = 1'b1;
          queue_byte((kind == pdpe_pkg::DEV_TABLET) ? pdpe_pkg::ID_TABLET :
                     ((kind == pdpe_pkg::DEV_JOYSTICK) ? pdpe_pkg::ID_JOYSTICK :
                      pdpe_pkg::ID_MOUSE), 1'b0, 1'b1);
          return;
        end
        if (any) begin
          b0 = 8'((pos_x >> 7) & 7) | btn |
               ((kind == pdpe_pkg::DEV_TABLET) ? 8'h08 : 8'h88);
          queue_byte(b0, 1'b0, 1'b0);
          queue_byte(8'(pos_x & 'h7F), 1'b0, 1'b0);
          queue_byte(8'((pos_y >> 7) & 7), 1'b0, 1'b0);
          queue_byte(8'(pos_y & 'h7F), 1'b0, 1'b1);
        end
      end
    end else if (link_kind == pdpe_pkg::LINK_IKAT) begin
      if (ikat_up && any) begin
        if (kind == pdpe_pkg::DEV_TABLET) begin
          x = clamp_int(pos_x * 'h3FF / SCREEN_X_MAX, 0, pdpe_pkg::IKAT_ABS_MAX);
          y = clamp_int(pos_y * 'h3FF / SCREEN_Y_MAX, 0, pdpe_pkg::IKAT_ABS_MAX);
          b0 = 8'h40 | btn | 8'((x >> 6) & 'hF);
          b1 = (moving ? 8'h20 : 8'h00) | 8'((y >> 6) & 'hF);
          b2 = 8'(x & 'h3F);
          b3 = 8'h80 | 8'(y & 'h3F);
        end else begin
          x = clamp_int(mov_x, -128, 127) & 'hFF;
          y = clamp_int(mov_y, -128, 127) & 'hFF;
          b0 = 8'h40 | btn | 8'((y >> 4) & 'hC) | 8'((x >> 6) & 3);
          b1 = 8'(x & 'h3F);
          b2 = 8'(y & 'h3F);
          b3 = 8'h00;
        end
        queue_byte(b0, 1'b1, 1'b0);
        queue_byte(b1, 1'b1, 1'b0);
        queue_byte(b2, 1'b1, 1'b0);
        queue_byte(b3, 1'b1, 1'b1);
        return;
      end
    end
    stationary = 1'b0;
    changed = 1'b0;
  endtask

  // watch the channels at each rising edge
  always @(posedge clk) begin
    pdpe_pkg::out_item_t want;
    if (!rst_n) begin
      link_kind = 2'd0;
      device_kind = 2'd0;
      step_size = 8'd1;
      slave_en = 1'b1;
      ikat_up = 1'b1;
      pos_x = 0; pos_y = 0; mov_x = 0; mov_y = 0;
      buttons = '0;
      moving = 1'b0; stationary = 1'b0; changed = 1'b0; identified = 1'b0;
      for (int i = 0; i < 4; i++) last_src[i] = '0;
      report_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          report_mismatch("unexpected byte", out_data.report_byte, 0);
        end else begin
          want = report_q.pop_front();
          if (out_data.report_byte != want.report_byte)
            report_mismatch("report_byte", out_data.report_byte, want.report_byte);
          if (out_data.report_link != want.report_link)
            report_mismatch("report_link", out_data.report_link, want.report_link);
          if (out_data.report_last != want.report_last)
            report_mismatch("report_last", out_data.report_last, want.report_last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pdpe_pkg::REG_LINK_KIND: link_kind = cfg_data[1:0];
          pdpe_pkg::REG_DEV_KIND:  device_kind = cfg_data[1:0];
          pdpe_pkg::REG_STEP_SIZE: step_size = cfg_data;
          pdpe_pkg::REG_SLAVE_EN:  slave_en = cfg_data[0];
          pdpe_pkg::REG_IKAT_UP:   ikat_up = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_data.opcode)
          pdpe_pkg::OP_BUTTON: do_button(in_data.button_id, in_data.button_level);
          pdpe_pkg::OP_SOURCE: do_source(in_data);
          pdpe_pkg::OP_POLL:   do_poll();
          default: begin
            pos_x = in_data.host_x;
            pos_y = in_data.host_y;
          end
        endcase
      end
    end
  end

  initial fail_count = 0;

endmodule

@@ verif/tb_pointer_device_packet_encoder.sv @@
`timescale 1ns / 1ps
module tb_pointer_device_packet_encoder;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  pdpe_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  pdpe_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [2:0]          cfg_index;
  logic [7:0]          cfg_data;
  int                  fail_count;
  int                  pending;

  int                  tx_idle_pct;
  int                  rx_stall_pct;
  int                  hold_req;
  int                  hold_left;
  int                  items_sent;
  pdpe_pkg::in_item_t  last_source_item;

  pointer_device_packet_encoder u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pdpe_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // offer one item, idling first at the sender's rate
  task automatic send_item(pdpe_pkg::in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_data = pdpe_pkg::in_item_t'({$urandom, $urandom});
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // hold the sender until every byte has come and the block has settled
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(logic [1:0] lk, logic [1:0] dk, logic [7:0] stp,
                            logic sen, logic iup);
    drain();
    write_reg(pdpe_pkg::REG_LINK_KIND, {6'($urandom), lk});
    write_reg(pdpe_pkg::REG_DEV_KIND, {6'($urandom), dk});
    write_reg(pdpe_pkg::REG_STEP_SIZE, stp);
    write_reg(pdpe_pkg::REG_SLAVE_EN, {7'($urandom), sen});
    write_reg(pdpe_pkg::REG_IKAT_UP, {7'($urandom), iup});
  endtask

  function automatic pdpe_pkg::in_item_t mk(logic [1:0] op);
    pdpe_pkg::in_item_t it;
    it = pdpe_pkg::in_item_t'({$urandom, $urandom});
    it.opcode = op;
    return it;
  endfunction

  function automatic pdpe_pkg::in_item_t mk_button(logic [2:0] id, logic lvl);
    pdpe_pkg::in_item_t it;
    it = mk(pdpe_pkg::OP_BUTTON);
    it.button_id = id;
    it.button_level = lvl;
    return it;
  endfunction

  function automatic pdpe_pkg::in_item_t mk_source(int x, int y, int w, int h);
    pdpe_pkg::in_item_t it;
    it = mk(pdpe_pkg::OP_SOURCE);
    it.source_x = 12'(x);
    it.source_y = 12'(y);
    it.source_width = 12'(w);
    it.source_height = 12'(h);
    return it;
  endfunction

  function automatic pdpe_pkg::in_item_t mk_host(int x, int y);
    pdpe_pkg::in_item_t it;
    it = mk(pdpe_pkg::OP_HOST);
    it.host_x = 10'(x);
    it.host_y = 10'(y);
    return it;
  endfunction

  // well-formed random item: mostly valid buttons, fresh coordinates and polls
  function automatic pdpe_pkg::in_item_t rand_item(pdpe_pkg::in_item_t prev_src);
    pdpe_pkg::in_item_t it;
    int r;
    r = $urandom_range(99);
    if (r < 35) begin
      it = mk_button(($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                               : 3'($urandom_range(5)), 1'($urandom));
    end else if (r < 55) begin
      if ($urandom_range(3) == 0) begin
        it = prev_src;
      end else begin
        it = mk(pdpe_pkg::OP_SOURCE);
        if ($urandom_range(1)) begin
          it.source_width = 12'($urandom_range(4095, 1));
          it.source_height = 12'($urandom_range(4095, 1));
          it.source_x = 12'($urandom_range(it.source_width));
          it.source_y = 12'($urandom_range(it.source_height));
        end
      end
    end else if (r < 90) begin
      it = mk(pdpe_pkg::OP_POLL);
    end else begin
      it = mk(pdpe_pkg::OP_HOST);
    end
    return it;
  endfunction

  task automatic run_random(int count);
    pdpe_pkg::in_item_t it;
    for (int i = 0; i < count; i++) begin
      it = rand_item(last_source_item);
      if (it.opcode == pdpe_pkg::OP_SOURCE) last_source_item = it;
      send_item(it);
    end
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, int count);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    run_random(count);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    items_sent = 0;
    last_source_item = mk_source(0, 0, 0, 0);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: identification, directions, buttons, scaling edges
    send_item(mk(pdpe_pkg::OP_POLL));
    send_item(mk(pdpe_pkg::OP_POLL));
    send_item(mk_button(pdpe_pkg::BTN_RIGHT, 1'b1));
    send_item(mk_button(pdpe_pkg::BTN_DOWN, 1'b1));
    send_item(mk(pdpe_pkg::OP_POLL));
    send_item(mk_button(pdpe_pkg::BTN_LEFT, 1'b1));
    send_item(mk_button(pdpe_pkg::BTN_RIGHT, 1'b0));
    send_item(mk_button(pdpe_pkg::BTN_LEFT, 1'b0));
    send_item(mk_button(pdpe_pkg::BTN_DOWN, 1'b0));
    send_item(mk(pdpe_pkg::OP_POLL));
    send_item(mk_button(pdpe_pkg::BTN_ONE, 1'b1));
    send_item(mk_button(pdpe_pkg::BTN_TWO, 1'b1));
    send_item(mk_button(3'd6, 1'b1));
    send_item(mk_button(3'd7, 1'b0));
    send_item(mk(pdpe_pkg::OP_POLL));
    send_item(mk_source(4095, 4095, 1, 1));
    send_item(mk_source(4095, 4095, 0, 0));
    send_item(mk_source(4095, 4095, 0, 0));
    send_item(mk(pdpe_pkg::OP_POLL));
    send_item(mk_host(1023, 1023));
    send_item(mk_source(0, 0, 4095, 4095));
    send_item(mk(pdpe_pkg::OP_POLL));
    send_item(mk_host(0, 0));
    send_item(mk(pdpe_pkg::OP_POLL));

    // IKAT tablet with the host position beyond the screen
    set_config(pdpe_pkg::LINK_IKAT, pdpe_pkg::DEV_TABLET, 8'd7, 1'b1, 1'b1);
    send_item(mk_host(1023, 1023));
    send_item(mk_button(pdpe_pkg::BTN_UP, 1'b1));
    send_item(mk(pdpe_pkg::OP_POLL));
    send_item(mk_button(pdpe_pkg::BTN_UP, 1'b0));
    send_item(mk(pdpe_pkg::OP_POLL));

    // random phases under several settings
    set_config(pdpe_pkg::LINK_SLAVE, pdpe_pkg::DEV_JOYSTICK, 8'd255, 1'b1, 1'b1);
    run_phase(0, 0, 15);
    set_config(pdpe_pkg::LINK_IKAT, pdpe_pkg::DEV_TABLET, 8'd3, 1'b0, 1'b1);
    run_phase(85, 0, 20);
    set_config(pdpe_pkg::LINK_IKAT, 2'd3, 8'd0, 1'b1, 1'b1);
    run_phase(0, 85, 10);

    // hold the receiver off while polls keep coming, then pause until empty
    @(negedge clk);
    hold_req = 300;
    for (int i = 0; i < 6; i++) begin
      send_item(mk_button(pdpe_pkg::BTN_LEFT, 1'b1));
      send_item(mk(pdpe_pkg::OP_POLL));
    end
    drain();
    run_phase(0, 85, 10);

    set_config(pdpe_pkg::LINK_SLAVE, pdpe_pkg::DEV_TABLET, 8'd128, 1'b1, 1'b0);
    run_phase(28, 28, 15);

    // links that carry nothing: no link, link kind three, disabled sides
    set_config(2'd2, pdpe_pkg::DEV_JOYSTICK, 8'd1, 1'b1, 1'b1);
    run_phase(0, 0, 3);
    set_config(2'd3, pdpe_pkg::DEV_JOYSTICK, 8'd1, 1'b1, 1'b1);
    run_phase(0, 0, 3);
    set_config(pdpe_pkg::LINK_SLAVE, 2'd0, 8'd1, 1'b0, 1'b1);
    run_phase(0, 0, 3);
    set_config(pdpe_pkg::LINK_IKAT, 2'd0, 8'd1, 1'b1, 1'b0);
    run_phase(0, 0, 3);

    drain();
    $display("covered %0d items over slave, IKAT and idle links", items_sent);
    $display("with all device kinds, step extremes and long receiver stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
src/pdpe_pkg.sv
src/pointer_device_packet_encoder.sv
verif/pdpe_checker.sv
verif/tb_pointer_device_packet_encoder.sv
